### hdl/bmp_palette_stream_decoder_core_assert.svh
// Assertion macros for the BMP palette stream decoder.
`ifndef BMP_PALETTE_STREAM_DECODER_CORE_ASSERT_SVH
`define BMP_PALETTE_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BMPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BMPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hdl/bmpd_pkg.sv
// Types and constants shared by the BMP palette stream decoder.
package bmpd_pkg;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  localparam int unsigned PALETTE_DEPTH = 256;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RGB_W     = 24;
  localparam int unsigned PIX_IDX_W = 20;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned DIM_W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DIM_H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PROD_W    = DIM_W_W + DIM_H_W;
  localparam int unsigned PAL_CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned PAL_AW    = $clog2(PALETTE_DEPTH);

  localparam logic [BYTE_W-1:0] SIG_B        = 8'h42;
  localparam logic [BYTE_W-1:0] SIG_M        = 8'h4D;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [31:0]       INFO_HDR_SIZE = 32'd40;

  localparam logic [31:0] POS_SIG0      = 32'd0;
  localparam logic [31:0] POS_SIG1      = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_HDR_SIZE  = 32'd17;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_BITCOUNT  = 32'd29;
  localparam logic [31:0] POS_CLR_USED  = 32'd49;
  localparam logic [31:0] POS_HDR_LAST  = 32'd53;
  localparam logic [31:0] HEADER_END    = 32'd54;

  localparam logic [STATUS_W-1:0] ST_PIXEL     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SIGNATURE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEADER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_PIXEL,
    PH_PAD,
    PH_IDLE
  } phase_e;

  typedef struct packed {
    logic                 valid;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic                 last_pixel;
    logic [STATUS_W-1:0]  status;
    logic                 use_ram;
  } issue_t;

endpackage

### hdl/bmpd_stream_if.sv
// Byte input and pixel output stream interfaces.
interface bmpd_in_if import bmpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface bmpd_out_if import bmpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [BYTE_W-1:0]    red;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    blue;
  logic [BYTE_W-1:0]    alpha;
  logic                 last_pixel;
  logic [STATUS_W-1:0]  status;

  modport source (
    output valid, output pixel_index, output red, output green, output blue,
    output alpha, output last_pixel, output status, input ready
  );
  modport sink (
    input valid, input pixel_index, input red, input green, input blue,
    input alpha, input last_pixel, input status, output ready
  );
endinterface

### hdl/bmpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmpd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bmpd_parser.sv
// File parser: header fields, palette loading and pixel position tracking.
module bmpd_parser import bmpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  bmpd_in_if.sink            in_i,
  input  logic               issue_ready_i,
  output issue_t             issue_o,
  output logic               ram_we_o,
  output logic [PAL_AW-1:0]  ram_waddr_o,
  output logic [RGB_W-1:0]   ram_wdata_o,
  output logic               ram_re_o,
  output logic [PAL_AW-1:0]  ram_raddr_o
);

  phase_e               phase_q, phase_d, phase_cur;
  logic [31:0]          pos_q, pos_d, pos_cur;
  logic [31:0]          fs_q, fs_d, fs_new;
  logic [31:0]          offset_q, offset_d;
  logic [DIM_W_W-1:0]   width_q, width_d;
  logic [DIM_H_W-1:0]   height_q, height_d;
  logic [15:0]          cbits_q, cbits_d;
  logic [PAL_CNT_W-1:0] entries_q, entries_d;
  logic [DIM_W_W-1:0]   col_q, col_d;
  logic [DIM_H_W-1:0]   row_q, row_d;
  logic [1:0]           pad_q, pad_d;
  logic [PIX_IDX_W-1:0] row_base_q, row_base_d;
  logic [15:0]          lane_q, lane_d;

  logic                 accept;
  logic [BYTE_W-1:0]    b;
  logic                 sig_fail, size_fail, dim_fail, hdr_fail;
  logic [STATUS_W-1:0]  hdr_status;
  logic [31:0]          loaded, cnt_raw;
  logic [PAL_CNT_W-1:0] entries_fin, pal_sat;
  logic [PROD_W-1:0]    base_prod;
  logic [31:0]          rel;
  logic                 in_pal;
  logic                 in_range, col_wrap, row_last, last;
  logic [1:0]           pad_new;
  logic [PIX_IDX_W-1:0] raster;
  issue_t               issue_d;

  assign accept     = in_i.valid && issue_ready_i;
  assign in_i.ready = issue_ready_i;
  assign b          = in_i.file_byte;
  assign phase_cur  = in_i.start_of_file ? PH_HEADER : phase_q;
  assign pos_cur    = in_i.start_of_file ? 32'd0 : pos_q;
  assign fs_new     = {b, fs_q[31:8]};

  assign sig_fail  = ((pos_cur == POS_SIG0) && (b != SIG_B)) ||
                     ((pos_cur == POS_SIG1) && (b != SIG_M));
  assign size_fail = (pos_cur == POS_HDR_SIZE) && (fs_new != INFO_HDR_SIZE);
  assign dim_fail  = ((pos_cur == POS_WIDTH) && (fs_new > 32'(MAX_WIDTH))) ||
                     ((pos_cur == POS_HEIGHT) && (fs_new > 32'(MAX_HEIGHT)));
  assign hdr_fail  = sig_fail || size_fail || dim_fail;
  assign hdr_status = sig_fail ? ST_SIGNATURE : (size_fail ? ST_HEADER : ST_TOO_LARGE);

  assign cnt_raw = ((fs_new == 32'd0) && (cbits_q <= 16'd8)) ?
                   (32'd1 << cbits_q[3:0]) : fs_new;
  assign pal_sat = (cnt_raw > 32'(PALETTE_DEPTH)) ?
                   PAL_CNT_W'(PALETTE_DEPTH) : PAL_CNT_W'(cnt_raw);

  assign loaded      = (offset_q > HEADER_END) ? ((offset_q - HEADER_END) >> 2) : 32'd0;
  assign entries_fin = (32'(entries_q) > loaded) ? PAL_CNT_W'(loaded) : entries_q;
  assign base_prod   = PROD_W'(height_q - 1'b1) * PROD_W'(width_q);

  assign rel    = pos_cur - HEADER_END;
  assign in_pal = {2'b00, rel[31:2]} < 32'(entries_q);

  assign in_range = 16'(b) < 16'(entries_q);
  assign col_wrap = (col_q + 1'b1) >= width_q;
  assign row_last = (row_q + 1'b1) >= height_q;
  assign last     = ((row_q + 1'b1) == height_q) && ((col_q + 1'b1) == width_q);
  assign pad_new  = 2'd0 - width_q[1:0];
  assign raster   = row_base_q + PIX_IDX_W'(col_q);

  always_comb begin : next_phase
    phase_d = phase_q;
    if (accept) begin
      phase_d = phase_cur;
      case (phase_cur)
        PH_HEADER: begin
          if (hdr_fail) begin
            phase_d = PH_IDLE;
          end else if (pos_cur == POS_HDR_LAST) begin
            if ((width_q == '0) || (height_q == '0)) begin
              phase_d = PH_IDLE;
            end else if (offset_q <= HEADER_END) begin
              phase_d = PH_PIXEL;
            end else begin
              phase_d = PH_PALETTE;
            end
          end
        end
        PH_PALETTE: begin
          if ((pos_cur + 32'd1) >= offset_q) phase_d = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (col_wrap) begin
            if (row_last) begin
              phase_d = PH_IDLE;
            end else if (pad_new != 2'd0) begin
              phase_d = PH_PAD;
            end
          end
        end
        PH_PAD: begin
          if (pad_q == 2'd1) phase_d = PH_PIXEL;
        end
        default: phase_d = phase_cur;
      endcase
    end
  end

  always_comb begin : datapath
    pos_d      = pos_q;
    fs_d       = fs_q;
    offset_d   = offset_q;
    width_d    = width_q;
    height_d   = height_q;
    cbits_d    = cbits_q;
    entries_d  = entries_q;
    col_d      = col_q;
    row_d      = row_q;
    pad_d      = pad_q;
    row_base_d = row_base_q;
    lane_d     = lane_q;
    issue_d    = '0;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    if (accept) begin
      pos_d = pos_cur;
      case (phase_cur)
        PH_HEADER: begin
          pos_d = pos_cur + 32'd1;
          fs_d  = fs_new;
          if (pos_cur == POS_OFFSET)   offset_d = fs_new;
          if (pos_cur == POS_WIDTH)    width_d  = DIM_W_W'(fs_new);
          if (pos_cur == POS_HEIGHT)   height_d = DIM_H_W'(fs_new);
          if (pos_cur == POS_BITCOUNT) cbits_d  = fs_new[31:16];
          if (pos_cur == POS_CLR_USED) entries_d = pal_sat;
          if (pos_cur == POS_HDR_LAST) begin
            entries_d  = entries_fin;
            col_d      = '0;
            row_d      = '0;
            row_base_d = PIX_IDX_W'(base_prod);
          end
          if (hdr_fail) begin
            issue_d.valid  = 1'b1;
            issue_d.status = hdr_status;
          end
        end
        PH_PALETTE: begin
          pos_d = pos_cur + 32'd1;
          if (in_pal) begin
            case (rel[1:0])
              2'd0:    lane_d[7:0]  = b;
              2'd1:    lane_d[15:8] = b;
              2'd2:    ram_we_o     = 1'b1;
              default: lane_d       = lane_q;
            endcase
          end
        end
        PH_PIXEL: begin
          issue_d.valid       = 1'b1;
          issue_d.pixel_index = raster;
          issue_d.last_pixel  = last;
          issue_d.status      = in_range ? ST_PIXEL : ST_BAD_INDEX;
          issue_d.use_ram     = in_range;
          ram_re_o            = in_range;
          if (col_wrap) begin
            col_d = '0;
            if (!row_last) begin
              row_d      = row_q + 1'b1;
              pad_d      = pad_new;
              row_base_d = row_base_q - PIX_IDX_W'(width_q);
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
        PH_PAD: pad_d = pad_q - 2'd1;
        default: pos_d = pos_cur;
      endcase
    end
  end

  assign issue_o     = issue_d;
  assign ram_waddr_o = rel[PAL_AW+1:2];
  assign ram_wdata_o = {b, lane_q[15:8], lane_q[7:0]};
  assign ram_raddr_o = b[PAL_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      fs_q       <= '0;
      offset_q   <= '0;
      width_q    <= '0;
      height_q   <= '0;
      cbits_q    <= '0;
      entries_q  <= '0;
      col_q      <= '0;
      row_q      <= '0;
      pad_q      <= '0;
      row_base_q <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      fs_q       <= fs_d;
      offset_q   <= offset_d;
      width_q    <= width_d;
      height_q   <= height_d;
      cbits_q    <= cbits_d;
      entries_q  <= entries_d;
      col_q      <= col_d;
      row_q      <= row_d;
      pad_q      <= pad_d;
      row_base_q <= row_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

endmodule

### hdl/bmpd_out_stage.sv
// Read-data stage and output register with stall handling.
module bmpd_out_stage import bmpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  issue_t           issue_i,
  output logic             issue_ready_o,
  input  logic [RGB_W-1:0] ram_rdata_i,
  bmpd_out_if.source       out_o
);

  issue_t               s1_q;
  logic                 out_valid_q;
  logic [PIX_IDX_W-1:0] idx_q;
  logic [RGB_W-1:0]     rgb_q;
  logic [BYTE_W-1:0]    alpha_q;
  logic                 last_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 out_free;

  assign out_free      = !out_valid_q || out_o.ready;
  assign issue_ready_o = !s1_q.valid || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue_ready_o) s1_q <= issue_i;
      if (out_free) out_valid_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_q.valid) begin
      idx_q    <= s1_q.pixel_index;
      rgb_q    <= s1_q.use_ram ? ram_rdata_i : '0;
      alpha_q  <= s1_q.use_ram ? ALPHA_OPAQUE : '0;
      last_q   <= s1_q.last_pixel;
      status_q <= s1_q.status;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_index = idx_q;
  assign out_o.red         = rgb_q[23:16];
  assign out_o.green       = rgb_q[15:8];
  assign out_o.blue        = rgb_q[7:0];
  assign out_o.alpha       = alpha_q;
  assign out_o.last_pixel  = last_q;
  assign out_o.status      = status_q;

endmodule

### hdl/bmp_palette_stream_decoder_core.sv
// Top level of the 8-bit palettised BMP stream decoder.
//
// in_i carries the file one byte per transaction; start_of_file marks byte 0
// of a new file and drops any file in progress. out_o carries at most one
// transaction per input byte: a pixel (raster index with row 0 at the top,
// RGB from the palette, alpha 255), an index beyond the palette, or an error
// status for a bad signature, an unsupported header or an oversize image.
// Throughput is one byte per cycle in every phase while out_o does not stall.
// A result reaches out_o through the read stage, which holds the synchronous
// palette memory read, and then the output register. Palette entries are
// written from bytes gathered per entry, so a pixel right after the last
// palette byte already reads the new entry.
// Reset puts the parser at byte 0 of the header; the palette memory is not
// cleared, and only entries loaded by the current file are ever read.
// When out_o stalls, the output register holds and one further result waits
// in the read stage; in_i.ready then drops until the output moves.
`include "bmp_palette_stream_decoder_core_assert.svh"

module bmp_palette_stream_decoder_core import bmpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmpd_in_if.sink    in_i,
  bmpd_out_if.source out_o
);

  issue_t              issue;
  logic                issue_ready;
  logic                ram_we;
  logic [PAL_AW-1:0]   ram_waddr;
  logic [RGB_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [PAL_AW-1:0]   ram_raddr;
  logic [RGB_W-1:0]    ram_rdata;

  bmpd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .issue_ready_i (issue_ready),
    .issue_o       (issue),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  bmpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bmpd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .issue_ready_o (issue_ready),
    .ram_rdata_i   (ram_rdata),
    .out_o         (out_o)
  );

  `BMPD_ASSERT(a_pixel_opaque, clk_i, rst_ni, out_o.valid && (out_o.status == ST_PIXEL) |-> (out_o.alpha == ALPHA_OPAQUE), "pixel result not opaque")
  `BMPD_ASSERT(a_error_clear, clk_i, rst_ni, out_o.valid && ((out_o.status == ST_SIGNATURE) || (out_o.status == ST_HEADER) || (out_o.status == ST_TOO_LARGE)) |-> (out_o.pixel_index == '0) && !out_o.last_pixel && (out_o.red == '0) && (out_o.alpha == '0), "error result carries data")
  `BMPD_ASSERT_NEVER(a_no_rw_overlap, clk_i, rst_ni, ram_we && ram_re, "palette write and read in one cycle")
  `BMPD_ASSERT_NEVER(a_no_read_stalled, clk_i, rst_ni, ram_re && !issue_ready, "palette read while read stage is held")

endmodule
